/* sv/fmbq_pkg.sv */
package fmbq_pkg;

  // storage size and field widths
  localparam int DEPTH    = 64;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int FAN_IN   = 8;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_MIDDLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_MIDDLE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POP_BACK    = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // number of nodes on one level of the read tree, level 0 being the cells
  function automatic int level_size(input int lvl);
    int n;
    n = DEPTH;
    for (int l = 0; l < lvl; l++) begin
      n = (n + FAN_IN - 1) / FAN_IN;
    end
    return n;
  endfunction

  // registered levels needed to reduce all cells to one node
  function automatic int tree_levels();
    int n;
    int l;
    n = DEPTH;
    l = 0;
    while (n > 1) begin
      n = (n + FAN_IN - 1) / FAN_IN;
      l++;
    end
    return l;
  endfunction

  localparam int TREE_LEVELS = tree_levels();
  localparam int LVL_W       = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

  // command broadcast to every cell
  typedef struct packed {
    logic             insert;
    logic             remove;
    logic [IDX_W-1:0] pos;
  } cell_cmd_t;

endpackage

/* sv/fmbq_cell.sv */
module fmbq_cell (
  input  logic                                    clk,
  input  fmbq_pkg::cell_cmd_t                     cmd,
  input  logic [fmbq_pkg::IDX_W-1:0]              idx,
  input  logic signed [fmbq_pkg::DATA_W-1:0]      push_value,
  input  logic signed [fmbq_pkg::DATA_W-1:0]      left,
  input  logic signed [fmbq_pkg::DATA_W-1:0]      right,
  output logic signed [fmbq_pkg::DATA_W-1:0]      q,
  output logic signed [fmbq_pkg::DATA_W-1:0]      rd
);

  // insert opens a gap at pos, remove closes the gap at pos
  always_ff @(posedge clk) begin
    priority if (cmd.insert && idx == cmd.pos) begin
      q <= push_value;
    end else if (cmd.insert && idx > cmd.pos) begin
      q <= left;
    end else if (cmd.remove && idx >= cmd.pos) begin
      q <= right;
    end else begin
      q <= q;
    end
  end

  // only the addressed cell drives the read tree
  assign rd = (idx == cmd.pos) ? q : '0;

endmodule

/* sv/fmbq_tree.sv */
module fmbq_tree (
  input  logic                               clk,
  input  logic signed [fmbq_pkg::DATA_W-1:0] leaf [fmbq_pkg::DEPTH],
  output logic signed [fmbq_pkg::DATA_W-1:0] root
);

  wire signed [fmbq_pkg::DATA_W-1:0] node [fmbq_pkg::TREE_LEVELS+1][fmbq_pkg::DEPTH];

  // level 0 is the masked cell outputs
  for (genvar gi = 0; gi < fmbq_pkg::DEPTH; gi++) begin : g_leaf
    assign node[0][gi] = leaf[gi];
  end

  // each level ors groups of up to eight nodes of the level below
  for (genvar gl = 1; gl <= fmbq_pkg::TREE_LEVELS; gl++) begin : g_level
    for (genvar gj = 0; gj < fmbq_pkg::DEPTH; gj++) begin : g_node
      if (gj < fmbq_pkg::level_size(gl)) begin : g_used
        logic signed [fmbq_pkg::DATA_W-1:0] acc;
        logic signed [fmbq_pkg::DATA_W-1:0] node_q;

        always_comb begin
          acc = '0;
          for (int k = 0; k < fmbq_pkg::FAN_IN; k++) begin
            if (gj * fmbq_pkg::FAN_IN + k < fmbq_pkg::level_size(gl - 1)) begin
              acc = acc | node[gl-1][gj * fmbq_pkg::FAN_IN + k];
            end
          end
        end

        always_ff @(posedge clk) begin
          node_q <= acc;
        end

        assign node[gl][gj] = node_q;
      end else begin : g_unused
        assign node[gl][gj] = '0;
      end
    end
  end

  assign root = node[fmbq_pkg::TREE_LEVELS][0];

endmodule

/* sv/front_middle_back_queue_core.sv */
// Queue with push and pop at the front, the middle and the back, holding up to
// fmbq_pkg::DEPTH signed 32-bit values in a row of shifting cells. A request is
// taken when start is high and busy is low. Push requests, unused kinds and pops
// of an empty queue go from accept straight to the apply state. Other pops pass
// first through the reduce state: the popped value is gathered from its
// cell through a registered or-tree of fan-in 8, one level per cycle, before the
// cells shift. Each request gives exactly one result, shown on data, status and
// occupancy for the single cycle in which done is high; the receiver cannot
// stall, so it must take the result in that cycle. busy is low again in the done
// cycle.
module front_middle_back_queue_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [fmbq_pkg::KIND_W-1:0]           kind,
  input  logic signed [fmbq_pkg::DATA_W-1:0]    value,
  output logic                                  busy,
  output logic                                  done,
  output logic signed [fmbq_pkg::DATA_W-1:0]    data,
  output logic [fmbq_pkg::STATUS_W-1:0]         status,
  output logic [fmbq_pkg::OCC_W-1:0]            occupancy
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REDUCE = 3'b010,
    S_APPLY  = 3'b100
  } state_t;

  state_t                              state;
  logic [fmbq_pkg::KIND_W-1:0]         op_kind;
  logic signed [fmbq_pkg::DATA_W-1:0]  op_value;
  logic [fmbq_pkg::CNT_W-1:0]          count;
  logic [fmbq_pkg::CNT_W-1:0]          count_next;
  logic [fmbq_pkg::LVL_W-1:0]          lvl_cnt;

  logic                                is_push;
  logic                                is_pop;
  logic                                pop_in;
  logic                                full;
  logic                                empty;
  logic                                do_insert;
  logic                                do_remove;
  logic [fmbq_pkg::IDX_W-1:0]          pos;
  fmbq_pkg::cell_cmd_t                 cmd;

  logic signed [fmbq_pkg::DATA_W-1:0]  cell_q  [fmbq_pkg::DEPTH];
  logic signed [fmbq_pkg::DATA_W-1:0]  cell_rd [fmbq_pkg::DEPTH];
  logic signed [fmbq_pkg::DATA_W-1:0]  root;

  // request decode
  assign is_push = (op_kind == fmbq_pkg::KIND_PUSH_FRONT) ||
                   (op_kind == fmbq_pkg::KIND_PUSH_MIDDLE) ||
                   (op_kind == fmbq_pkg::KIND_PUSH_BACK);
  assign is_pop  = (op_kind == fmbq_pkg::KIND_POP_FRONT) ||
                   (op_kind == fmbq_pkg::KIND_POP_MIDDLE) ||
                   (op_kind == fmbq_pkg::KIND_POP_BACK);
  assign pop_in  = (kind == fmbq_pkg::KIND_POP_FRONT) ||
                   (kind == fmbq_pkg::KIND_POP_MIDDLE) ||
                   (kind == fmbq_pkg::KIND_POP_BACK);
  assign full      = (count == fmbq_pkg::CNT_W'(fmbq_pkg::DEPTH));
  assign empty     = (count == '0);
  assign do_insert = is_push && !full;
  assign do_remove = is_pop && !empty;
  assign busy      = (state != S_IDLE);

  // position of the insert or remove
  always_comb begin
    unique case (op_kind)
      fmbq_pkg::KIND_PUSH_MIDDLE: pos = fmbq_pkg::IDX_W'(count >> 1);
      fmbq_pkg::KIND_PUSH_BACK:   pos = fmbq_pkg::IDX_W'(count);
      fmbq_pkg::KIND_POP_MIDDLE:  pos = fmbq_pkg::IDX_W'((count - 1'b1) >> 1);
      fmbq_pkg::KIND_POP_BACK:    pos = fmbq_pkg::IDX_W'(count - 1'b1);
      default:                    pos = '0;
    endcase
  end

  // cell command, shifts only in the apply cycle
  always_comb begin
    cmd.insert = (state == S_APPLY) && do_insert;
    cmd.remove = (state == S_APPLY) && do_remove;
    cmd.pos    = pos;
  end

  assign count_next = count + fmbq_pkg::CNT_W'(do_insert) - fmbq_pkg::CNT_W'(do_remove);

  // row of cells, each taking from its neighbor on a shift
  for (genvar gi = 0; gi < fmbq_pkg::DEPTH; gi++) begin : g_cell
    logic signed [fmbq_pkg::DATA_W-1:0] left_in;
    logic signed [fmbq_pkg::DATA_W-1:0] right_in;

    if (gi == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_left
      assign left_in = cell_q[gi-1];
    end

    if (gi == fmbq_pkg::DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_right
      assign right_in = cell_q[gi+1];
    end

    fmbq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (fmbq_pkg::IDX_W'(gi)),
      .push_value (op_value),
      .left       (left_in),
      .right      (right_in),
      .q          (cell_q[gi]),
      .rd         (cell_rd[gi])
    );
  end

  // read path for the popped value
  fmbq_tree u_tree (
    .clk  (clk),
    .leaf (cell_rd),
    .root (root)
  );

  // request payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_kind  <= kind;
      op_value <= value;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      if (do_remove) begin
        data <= root;
      end else if (is_pop) begin
        data <= -32'sd1;
      end else begin
        data <= '0;
      end
      if (is_push && full) begin
        status <= fmbq_pkg::STATUS_FULL;
      end else if (is_pop && empty) begin
        status <= fmbq_pkg::STATUS_EMPTY;
      end else begin
        status <= fmbq_pkg::STATUS_OK;
      end
      occupancy <= fmbq_pkg::OCC_W'(count_next);
    end
  end

  // sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      lvl_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lvl_cnt <= '0;
            state   <= (pop_in && !empty) ? S_REDUCE : S_APPLY;
          end
        end
        S_REDUCE: begin
          if (lvl_cnt == fmbq_pkg::LVL_W'(fmbq_pkg::TREE_LEVELS - 1)) begin
            lvl_cnt <= '0;
            state   <= S_APPLY;
          end else begin
            lvl_cnt <= lvl_cnt + 1'b1;
          end
        end
        S_APPLY: begin
          count <= count_next;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmbq_pkg::*;

  // kinds the block treats as no operation
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  localparam int RANDOM_OPS   = 1950;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = TREE_LEVELS + 8;
  localparam int MAX_GAP      = 12;

  localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] VAL_ONES = -32'sd1;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } queue_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
  } queue_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [KIND_W-1:0] kind = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic busy;
  logic done;
  logic signed [DATA_W-1:0] data;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0] occupancy;

  queue_req_t  req_backlog[$];
  queue_resp_t resp_due[$];
  logic signed [DATA_W-1:0] shadow_row[$];

  int  mismatch_count = 0;
  int  reqs_taken = 0;
  int  reqs_total = 0;
  int  idle_cycles = 0;
  int  burst_left = 8;
  int  gap_left = 0;
  logic req_taken = 1'b0;

  front_middle_back_queue_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .value     (value),
    .busy      (busy),
    .done      (done),
    .data      (data),
    .status    (status),
    .occupancy (occupancy)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the shadow queue and queue up its response
  task automatic apply_queue_op(input queue_req_t r);
    queue_resp_t resp;
    int n;
    n = shadow_row.size();
    resp.data   = '0;
    resp.status = STATUS_OK;
    case (r.kind)
      KIND_PUSH_FRONT, KIND_PUSH_MIDDLE, KIND_PUSH_BACK: begin
        if (n >= DEPTH) begin
          resp.status = STATUS_FULL;
        end else if (r.kind == KIND_PUSH_FRONT) begin
          shadow_row.push_front(r.value);
        end else if (r.kind == KIND_PUSH_MIDDLE) begin
          shadow_row.insert(n / 2, r.value);
        end else begin
          shadow_row.push_back(r.value);
        end
      end
      KIND_POP_FRONT, KIND_POP_MIDDLE, KIND_POP_BACK: begin
        if (n == 0) begin
          resp.data   = VAL_ONES;
          resp.status = STATUS_EMPTY;
        end else if (r.kind == KIND_POP_FRONT) begin
          resp.data = shadow_row.pop_front();
        end else if (r.kind == KIND_POP_MIDDLE) begin
          resp.data = shadow_row[(n - 1) / 2];
          shadow_row.delete((n - 1) / 2);
        end else begin
          resp.data = shadow_row.pop_back();
        end
      end
      default: begin
      end
    endcase
    resp.occupancy = OCC_W'(shadow_row.size());
    resp_due.push_back(resp);
    reqs_taken++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return VAL_ONES;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v);
    queue_req_t r;
    r.kind  = k;
    r.value = v;
    req_backlog.push_back(r);
  endtask

  // driver: bursts of requests separated by random gaps
  always @(negedge clk) begin : drive
    queue_req_t r;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        r = req_backlog.pop_front();
        start <= 1'b1;
        kind  <= r.kind;
        value <= r.value;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check each response, then record a newly taken request
  always @(posedge clk) begin : watch
    queue_resp_t want;
    logic taken;
    logic active;
    taken  = !rst && start && !busy;
    active = taken;
    if (!rst && done) begin
      active = 1'b1;
      if (resp_due.size() == 0) begin
        $display("%0t: unexpected response data=%0d status=%0d occupancy=%0d",
                 $time, data, status, occupancy);
        mismatch_count++;
      end else begin
        want = resp_due.pop_front();
        if (data !== want.data) begin
          $display("%0t: data expected %0d actual %0d", $time, want.data, data);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          mismatch_count++;
        end
        if (occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                   occupancy);
          mismatch_count++;
        end
      end
    end
    if (taken) begin
      apply_queue_op('{kind: kind, value: value});
    end
    req_taken = taken;
    // watchdog on cycles with no progress
    idle_cycles = active ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int push_pct;
    int seg_len;
    int roll;
    logic [KIND_W-1:0] k;

    // empty-queue pops and spare kinds
    add_req(KIND_POP_FRONT, pick_value());
    add_req(KIND_POP_MIDDLE, VAL_MAX);
    add_req(KIND_POP_BACK, VAL_MIN);
    add_req(KIND_SPARE_A, VAL_ONES);
    add_req(KIND_SPARE_B, VAL_MAX);
    // build up and take apart through every position
    add_req(KIND_PUSH_MIDDLE, VAL_MAX);
    add_req(KIND_PUSH_FRONT, VAL_MIN);
    add_req(KIND_PUSH_BACK, '0);
    add_req(KIND_PUSH_MIDDLE, VAL_ONES);
    add_req(KIND_PUSH_MIDDLE, 32'sd1);
    add_req(KIND_SPARE_A, '0);
    add_req(KIND_POP_MIDDLE, '0);
    add_req(KIND_POP_FRONT, '0);
    add_req(KIND_POP_BACK, VAL_ONES);
    add_req(KIND_POP_MIDDLE, '0);
    add_req(KIND_POP_MIDDLE, '0);
    add_req(KIND_POP_MIDDLE, '0);
    add_req(KIND_PUSH_BACK, 32'sh55555555);
    add_req(KIND_PUSH_FRONT, 32'shaaaaaaaa);
    add_req(KIND_POP_MIDDLE, '0);
    add_req(KIND_POP_BACK, '0);
    add_req(KIND_SPARE_B, '0);

    // random segments that lean toward filling or draining the queue
    while (req_backlog.size() < RANDOM_OPS + 22) begin
      case ($urandom_range(0, 4))
        0: push_pct = 95;
        1: push_pct = 85;
        2: push_pct = 50;
        3: push_pct = 15;
        default: push_pct = 5;
      endcase
      seg_len = $urandom_range(20, 120);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          k = $urandom_range(0, 1) ? KIND_SPARE_B : KIND_SPARE_A;
        end else if (roll < push_pct) begin
          k = KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_PUSH_BACK));
        end else begin
          k = KIND_W'($urandom_range(KIND_POP_FRONT, KIND_POP_BACK));
        end
        add_req(k, pick_value());
      end
    end
    reqs_total = req_backlog.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (reqs_taken < reqs_total || resp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
